/* sv/ucarl_pkg.sv */
// ----------------------------------------------------------------------------
// ucarl_pkg
// Shared types, character codes and the microcode program of the command link.
// ----------------------------------------------------------------------------
package ucarl_pkg;

    // item kinds on the request tuser bit
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // character codes
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    localparam int TIMEOUT_W     = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

    // program counter and program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] P_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] P_ECHO  = 4'd1;
    localparam logic [PC_W-1:0] P_WAIT  = 4'd2;
    localparam logic [PC_W-1:0] P_BANG  = 4'd3;
    localparam logic [PC_W-1:0] P_A     = 4'd4;
    localparam logic [PC_W-1:0] P_D     = 4'd5;
    localparam logic [PC_W-1:0] P_C     = 4'd6;
    localparam logic [PC_W-1:0] P_EQ    = 4'd7;
    localparam logic [PC_W-1:0] P_DIGIT = 4'd8;
    localparam logic [PC_W-1:0] P_HASH  = 4'd9;
    localparam logic [PC_W-1:0] P_CR    = 4'd10;
    localparam logic [PC_W-1:0] P_LF    = 4'd11;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_ECHO  = 3'd1,
        OP_WAIT  = 3'd2,
        OP_CHAR  = 3'd3,
        OP_DIGIT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        JC_NEXT     = 2'd0,
        JC_GOTO     = 2'd1,
        JC_IF_FRAME = 2'd2
    } jc_t;

    typedef struct packed {
        op_t             op;
        logic [7:0]      ch;
        logic            last;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // parser events raised on an accepted request
    typedef struct packed {
        logic send_frame;
        logic load_sample;
    } evt_t;

    function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_IDLE, ch: 8'h00, last: 1'b0, jc: JC_GOTO, target: P_IDLE};
        case (pc)
            P_IDLE:  w = '{op: OP_IDLE,  ch: 8'h00,   last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_ECHO:  w = '{op: OP_ECHO,  ch: 8'h00,   last: 1'b0, jc: JC_IF_FRAME,
                           target: P_WAIT};
            P_WAIT:  w = '{op: OP_WAIT,  ch: 8'h00,   last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_BANG:  w = '{op: OP_CHAR,  ch: CH_BANG, last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_A:     w = '{op: OP_CHAR,  ch: CH_A,    last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_D:     w = '{op: OP_CHAR,  ch: CH_D,    last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_C:     w = '{op: OP_CHAR,  ch: CH_C,    last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_EQ:    w = '{op: OP_CHAR,  ch: CH_EQ,   last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_DIGIT: w = '{op: OP_DIGIT, ch: 8'h00,   last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_HASH:  w = '{op: OP_CHAR,  ch: CH_HASH, last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_CR:    w = '{op: OP_CHAR,  ch: CH_CR,   last: 1'b0, jc: JC_NEXT, target: P_IDLE};
            P_LF:    w = '{op: OP_CHAR,  ch: CH_LF,   last: 1'b1, jc: JC_GOTO, target: P_IDLE};
            default: w = '{op: OP_IDLE,  ch: 8'h00,   last: 1'b0, jc: JC_GOTO, target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/ucarl_parser.sv */
// ----------------------------------------------------------------------------
// ucarl_parser
// Command parser, acknowledgement state and resend timer.
// ----------------------------------------------------------------------------
module ucarl_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  logic                            in_kind,
    input  logic [7:0]                      in_byte,
    input  logic [ucarl_pkg::TIMEOUT_W-1:0] timeout,
    output ucarl_pkg::evt_t                 evt
);

    logic                            collecting_reg, collecting_next;
    logic [7:0]                      chars_reg [3];
    logic [7:0]                      chars_next [3];
    logic [1:0]                      len_reg, len_next;
    logic                            awaiting_reg, awaiting_next;
    logic [ucarl_pkg::TIMEOUT_W-1:0] ticks_reg, ticks_next;
    logic                            is_rst, is_ok;

    always_comb begin
        collecting_next = collecting_reg;
        chars_next      = chars_reg;
        len_next        = len_reg;
        awaiting_next   = awaiting_reg;
        ticks_next      = ticks_reg;
        evt             = '0;

        is_rst = (len_reg == 2'd3) && (chars_reg[0] == ucarl_pkg::CH_R) &&
                 (chars_reg[1] == ucarl_pkg::CH_S) && (chars_reg[2] == ucarl_pkg::CH_T);
        is_ok  = !is_rst && (len_reg >= 2'd2) && (chars_reg[0] == ucarl_pkg::CH_O) &&
                 (chars_reg[1] == ucarl_pkg::CH_K);

        if (in_accept) begin
            if (in_kind == ucarl_pkg::KIND_BYTE) begin
                if (!collecting_reg) begin
                    if (in_byte == ucarl_pkg::CH_BANG) begin
                        collecting_next = 1'b1;
                        len_next        = 2'd0;
                    end
                end else if (in_byte == ucarl_pkg::CH_HASH) begin
                    collecting_next = 1'b0;
                    if (is_rst && !awaiting_reg) begin
                        evt.send_frame  = 1'b1;
                        evt.load_sample = 1'b1;
                        ticks_next      = timeout;
                        awaiting_next   = 1'b1;
                    end else if (is_ok && awaiting_reg) begin
                        awaiting_next = 1'b0;
                    end
                end else if (len_reg != 2'd3) begin
                    // only the first three command bytes are kept
                    chars_next[len_reg] = in_byte;
                    len_next            = len_reg + 2'd1;
                end
            end else if (awaiting_reg) begin
                if (ticks_reg[ucarl_pkg::TIMEOUT_W-1:1] == '0) begin
                    evt.send_frame = 1'b1;
                    ticks_next     = timeout;
                end else begin
                    ticks_next = ticks_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            chars_reg      <= '{default: 8'h00};
            len_reg        <= 2'd0;
            awaiting_reg   <= 1'b0;
            ticks_reg      <= '0;
        end else begin
            collecting_reg <= collecting_next;
            chars_reg      <= chars_next;
            len_reg        <= len_next;
            awaiting_reg   <= awaiting_next;
            ticks_reg      <= ticks_next;
        end
    end

endmodule

/* sv/ucarl_dabble.sv */
// ----------------------------------------------------------------------------
// ucarl_dabble
// Holds the latched sample and converts it to decimal, one bit per cycle.
// ----------------------------------------------------------------------------
module ucarl_dabble #(
    parameter int ADC_BITS = 12,
    parameter int NDIG     = 4,
    localparam int CNT_W   = $clog2(ADC_BITS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ADC_BITS-1:0]   sample,
    output logic                  busy,
    output logic [NDIG*4-1:0]     bcd
);

    logic [ADC_BITS-1:0] bin_reg, bin_next;
    logic [NDIG*4-1:0]   bcd_reg, bcd_next;
    logic [NDIG*4-1:0]   adj;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                         : bcd_reg[i*4 +: 4];
        end
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            bin_next  = sample;
            bcd_next  = '0;
            cnt_next  = CNT_W'(ADC_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // add-3 then shift in the next binary bit
            bcd_next  = {adj[NDIG*4-2:0], bin_reg[ADC_BITS-1]};
            bin_next  = {bin_reg[ADC_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

/* sv/ucarl_seq.sv */
// ----------------------------------------------------------------------------
// ucarl_seq
// Microcode sequencer: steps through the program and drives the output slot.
// ----------------------------------------------------------------------------
module ucarl_seq #(
    parameter int NDIG   = 4,
    localparam int DIG_W = $clog2(NDIG)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic              in_kind,
    input  logic [7:0]        in_byte,
    input  ucarl_pkg::evt_t   evt,
    input  logic              conv_busy,
    input  logic [NDIG*4-1:0] bcd,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    logic [ucarl_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                       frame_pend_reg, frame_pend_next;
    logic [7:0]                 echo_reg, echo_next;
    logic [DIG_W-1:0]           dig_idx_reg, dig_idx_next;
    logic                       started_reg, started_next;
    logic                       tvalid_reg, tvalid_next;
    logic [7:0]                 tdata_reg, tdata_next;
    logic                       tlast_reg, tlast_next;

    ucarl_pkg::ctrl_t ctrl;
    logic             out_free;
    logic             emit, done;
    logic [7:0]       emit_data;
    logic             emit_last;
    logic [3:0]       digit;

    always_comb begin
        ctrl            = ucarl_pkg::rom_word(pc_reg);
        out_free        = !tvalid_reg || m_tready;
        digit           = bcd[dig_idx_reg*4 +: 4];
        pc_next         = pc_reg;
        frame_pend_next = frame_pend_reg;
        echo_next       = echo_reg;
        dig_idx_next    = dig_idx_reg;
        started_next    = started_reg;
        emit            = 1'b0;
        done            = 1'b0;
        emit_data       = ctrl.ch;
        emit_last       = ctrl.last;

        case (ctrl.op)
            ucarl_pkg::OP_IDLE: begin
                dig_idx_next = DIG_W'(NDIG - 1);
                started_next = 1'b0;
                if (in_accept) begin
                    echo_next = in_byte;
                    if (in_kind == ucarl_pkg::KIND_BYTE) begin
                        pc_next         = ucarl_pkg::P_ECHO;
                        frame_pend_next = evt.send_frame;
                    end else if (evt.send_frame) begin
                        pc_next = ucarl_pkg::P_WAIT;
                    end
                end
            end
            ucarl_pkg::OP_ECHO: begin
                emit_data = echo_reg;
                emit_last = !frame_pend_reg;
                emit      = out_free;
                done      = out_free;
            end
            ucarl_pkg::OP_WAIT: begin
                done = !conv_busy;
            end
            ucarl_pkg::OP_CHAR: begin
                emit = out_free;
                done = out_free;
            end
            ucarl_pkg::OP_DIGIT: begin
                emit_data = {ucarl_pkg::CH_DIGIT_HI, digit};
                if (!started_reg && digit == 4'd0 && dig_idx_reg != '0) begin
                    // leading zero: skip without output
                    dig_idx_next = dig_idx_reg - 1'b1;
                end else if (out_free) begin
                    emit         = 1'b1;
                    started_next = 1'b1;
                    if (dig_idx_reg == '0) begin
                        done = 1'b1;
                    end else begin
                        dig_idx_next = dig_idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                pc_next = ucarl_pkg::P_IDLE;
            end
        endcase

        if (done) begin
            case (ctrl.jc)
                ucarl_pkg::JC_NEXT:     pc_next = pc_reg + 1'b1;
                ucarl_pkg::JC_GOTO:     pc_next = ctrl.target;
                ucarl_pkg::JC_IF_FRAME: pc_next = frame_pend_reg ? ctrl.target
                                                                 : ucarl_pkg::P_IDLE;
                default:                pc_next = ucarl_pkg::P_IDLE;
            endcase
        end

        tvalid_next = emit ? 1'b1 : (tvalid_reg && !m_tready);
        tdata_next  = emit ? emit_data : tdata_reg;
        tlast_next  = emit ? emit_last : tlast_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= ucarl_pkg::P_IDLE;
            frame_pend_reg <= 1'b0;
            started_reg    <= 1'b0;
            dig_idx_reg    <= '0;
            tvalid_reg     <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            frame_pend_reg <= frame_pend_next;
            started_reg    <= started_next;
            dig_idx_reg    <= dig_idx_next;
            tvalid_reg     <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        echo_reg  <= echo_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    assign in_ready = (ctrl.op == ucarl_pkg::OP_IDLE);
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    // program counter stays inside the program
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= ucarl_pkg::P_LF)
        else $error("pc left the program");

    // digits are only read once the conversion has finished
    a_digit_after_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == ucarl_pkg::P_DIGIT) |-> !conv_busy)
        else $error("digit read during conversion");

    // final line feed of a frame returns the sequencer to idle
    a_lf_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == ucarl_pkg::P_LF && out_free) |=> pc_reg == ucarl_pkg::P_IDLE)
        else $error("no return to idle after frame");

    // no request is taken while a frame is still being produced
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg != ucarl_pkg::P_IDLE) |-> !in_ready)
        else $error("ready outside idle");

endmodule

/* sv/uart_command_ack_retry_link.sv */
// ----------------------------------------------------------------------------
// uart_command_ack_retry_link
// Serial command link that echoes bytes and reports the converter sample.
// ----------------------------------------------------------------------------
// Each request is a received byte (tuser 0) or one timer tick (tuser 1). A byte
// is echoed and parsed; "!RST#" while idle latches adc_sample and sends
// "!ADC=<decimal>#\r\n", repeated every ack_timeout_ticks ticks until "!OK#"
// arrives. The block takes one request at a time, run by a small microcode
// program. A report frame waits for the bit-serial decimal conversion of the
// sample, which yields up to NDIG digits, where NDIG is the decimal width of a
// full-scale sample (4 at 12 bits); output stalls hold the sequencer.
module uart_command_ack_retry_link #(
    parameter int ADC_BITS  = 12,
    localparam int S_DATA_W = ((8 + ADC_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,     // ack_timeout_ticks
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,    // rx_byte, adc_sample, zero pad
    input  logic                 s_axis_tuser,    // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,    // tx_byte
    output logic                 m_axis_tlast
);

    localparam longint MAX_VAL = (64'd1 << ADC_BITS) - 64'd1;
    localparam int     NDIG    = (MAX_VAL >= 10000) ? 5 : ((MAX_VAL >= 1000) ? 4 : 3);

    logic [ucarl_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                            in_accept;
    ucarl_pkg::evt_t                 evt;
    logic                            conv_busy;
    logic [NDIG*4-1:0]               bcd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ucarl_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    ucarl_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata[7:0]),
        .timeout   (timeout_reg),
        .evt       (evt)
    );

    ucarl_dabble #(
        .ADC_BITS (ADC_BITS),
        .NDIG     (NDIG)
    ) u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_accept && evt.load_sample),
        .sample  (s_axis_tdata[8 +: ADC_BITS]),
        .busy    (conv_busy),
        .bcd     (bcd)
    );

    ucarl_seq #(
        .NDIG (NDIG)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata[7:0]),
        .evt       (evt),
        .conv_busy (conv_busy),
        .bcd       (bcd),
        .in_ready  (s_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast)
    );

endmodule

/* tb/tb_uart_command_ack_retry_link.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_command_ack_retry_link
// Self-checking bench for the serial command link with acknowledged reports.
// ----------------------------------------------------------------------------
// Requests (received bytes and timer ticks) come from a pending queue and are
// driven with random gaps. Every accepted request goes through a behavioral
// model of the echo, the command parser and the resend timer, which queues the
// bytes the link must transmit. A monitor on the result side checks each byte
// and its tlast flag in order. Directed runs cover the corner commands and the
// timeout extremes. Random runs under several timeout settings follow, one of
// them with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_uart_command_ack_retry_link;

    localparam int ADC_BITS    = 12;
    localparam int S_DATA_W    = ((8 + ADC_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYC  = 40;
    localparam int HOLD_CYC    = 400;
    localparam int MAX_PRINTED = 30;

    typedef struct {
        logic                kind;
        logic [7:0]          rx_byte;
        logic [ADC_BITS-1:0] sample;
    } link_req_t;

    typedef struct {
        logic [7:0] tx_byte;
        logic       last;
    } tx_byte_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [15:0]         cfg_wr_data   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic                m_axis_tlast;

    // requests still to be driven, and bytes the link still owes us
    link_req_t rx_pending[$];
    tx_byte_t  tx_expected[$];

    // model state of the link
    logic        collecting   = 1'b0;
    logic [7:0]  cmd_chars[3] = '{8'h00, 8'h00, 8'h00};
    int          cmd_len      = 0;
    logic        awaiting_ack = 1'b0;
    logic [ADC_BITS-1:0] held_sample = '0;
    logic [15:0] ticks_left   = '0;
    logic [15:0] ack_timeout  = ucarl_pkg::TIMEOUT_RESET;

    int  err_count     = 0;
    int  queued_count  = 0;
    int  req_count     = 0;
    int  checked_count = 0;
    int  frame_count   = 0;
    int  resend_count  = 0;
    int  ack_count     = 0;
    int  send_gap      = 0;
    int  sink_gap      = 0;
    int  hold_left     = 0;
    logic hold_req     = 1'b0;
    bit  calm          = 1'b0;

    uart_command_ack_retry_link #(
        .ADC_BITS(ADC_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // ---------------- model of the link ----------------

    task automatic push_tx(input logic [7:0] b);
        tx_byte_t t;
        t.tx_byte = b;
        t.last    = 1'b0;
        tx_expected.push_back(t);
    endtask

    task automatic push_report_frame();
        logic [3:0] digits[$];
        int v;
        push_tx(ucarl_pkg::CH_BANG);
        push_tx(ucarl_pkg::CH_A);
        push_tx(ucarl_pkg::CH_D);
        push_tx(ucarl_pkg::CH_C);
        push_tx(ucarl_pkg::CH_EQ);
        v = held_sample;
        do begin
            digits.push_front(4'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) push_tx({ucarl_pkg::CH_DIGIT_HI, digits[i]});
        push_tx(ucarl_pkg::CH_HASH);
        push_tx(ucarl_pkg::CH_CR);
        push_tx(ucarl_pkg::CH_LF);
        frame_count++;
    endtask

    task automatic predict_link(input logic kind, input logic [7:0] b,
                                input logic [ADC_BITS-1:0] sample);
        int  before_n;
        bit  is_rst;
        bit  is_ok;
        before_n = tx_expected.size();
        req_count++;
        if (kind == ucarl_pkg::KIND_BYTE) begin
            push_tx(b);
            if (!collecting) begin
                if (b == ucarl_pkg::CH_BANG) begin
                    collecting = 1'b1;
                    cmd_len    = 0;
                end
            end else if (b == ucarl_pkg::CH_HASH) begin
                is_rst = cmd_len >= 3 && cmd_chars[0] == ucarl_pkg::CH_R &&
                         cmd_chars[1] == ucarl_pkg::CH_S &&
                         cmd_chars[2] == ucarl_pkg::CH_T;
                is_ok  = !is_rst && cmd_len >= 2 && cmd_chars[0] == ucarl_pkg::CH_O &&
                         cmd_chars[1] == ucarl_pkg::CH_K;
                collecting = 1'b0;
                if (is_rst && !awaiting_ack) begin
                    held_sample = sample;
                    push_report_frame();
                    ticks_left   = ack_timeout;
                    awaiting_ack = 1'b1;
                end else if (is_ok && awaiting_ack) begin
                    awaiting_ack = 1'b0;
                    ack_count++;
                end
            end else if (cmd_len < 3) begin
                // only the first three command bytes are kept
                cmd_chars[cmd_len] = b;
                cmd_len++;
            end
        end else if (awaiting_ack) begin
            if (ticks_left <= 16'd1) begin
                push_report_frame();
                ticks_left = ack_timeout;
                resend_count++;
            end else begin
                ticks_left--;
            end
        end
        if (tx_expected.size() > before_n) tx_expected[tx_expected.size() - 1].last = 1'b1;
    endtask

    // ---------------- request side ----------------

    function automatic int pick_gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        link_req_t req;
        logic      nxt_valid;
        int        nxt_gap;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            nxt_valid = s_axis_tvalid;
            nxt_gap   = send_gap;
            if (s_axis_tvalid && s_axis_tready) begin
                nxt_valid = 1'b0;
                nxt_gap   = (!calm && $urandom_range(0, 3) == 0) ? pick_gap_len() : 0;
            end
            if (!nxt_valid) begin
                if (nxt_gap != 0) begin
                    nxt_gap--;
                end else if (rx_pending.size() != 0) begin
                    req = rx_pending.pop_front();
                    nxt_valid = 1'b1;
                    s_axis_tuser <= req.kind;
                    s_axis_tdata <= S_DATA_W'({req.sample, req.rx_byte});
                end
            end
            s_axis_tvalid <= nxt_valid;
            send_gap      <= nxt_gap;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predict_link(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8 +: ADC_BITS]);
        end
    end

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYC;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) sink_gap <= pick_gap_len();
        end
    end

    always @(posedge aclk) begin
        tx_byte_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            checked_count++;
            if (tx_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = tx_expected.pop_front();
                if (m_axis_tdata !== want.tx_byte) begin
                    report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                              m_axis_tdata, want.tx_byte));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("tlast %0b on byte %02h, expected %0b",
                                              m_axis_tlast, want.tx_byte, want.last));
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [ADC_BITS-1:0] rand_sample();
        logic [ADC_BITS-1:0] v;
        v = ADC_BITS'($urandom);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return v >> $urandom_range(0, ADC_BITS - 1);
        endcase
    endfunction

    task automatic queue_item(input logic kind, input logic [7:0] b,
                              input logic [ADC_BITS-1:0] sample);
        link_req_t req;
        req.kind    = kind;
        req.rx_byte = b;
        req.sample  = sample;
        rx_pending.push_back(req);
        queued_count++;
    endtask

    // "!" body, some random filler bytes, then "#" carrying the sample
    task automatic queue_cmd(input string body, input int extra,
                             input logic [ADC_BITS-1:0] sample);
        logic [7:0] b;
        queue_item(ucarl_pkg::KIND_BYTE, ucarl_pkg::CH_BANG, rand_sample());
        foreach (body[i]) queue_item(ucarl_pkg::KIND_BYTE, body[i], rand_sample());
        repeat (extra) begin
            b = 8'($urandom);
            if (b == ucarl_pkg::CH_HASH) b = ucarl_pkg::CH_BANG;
            queue_item(ucarl_pkg::KIND_BYTE, b, rand_sample());
        end
        queue_item(ucarl_pkg::KIND_BYTE, ucarl_pkg::CH_HASH, sample);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_item(ucarl_pkg::KIND_TICK, 8'($urandom), rand_sample());
    endtask

    task automatic queue_random(input int budget);
        int stop_at;
        int r;
        stop_at = queued_count + budget;
        while (queued_count < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                queue_cmd("RST", $urandom_range(0, 2), rand_sample());
            end else if (r < 45) begin
                queue_ticks($urandom_range(1, 6));
            end else if (r < 65) begin
                queue_cmd("OK", $urandom_range(0, 2), rand_sample());
            end else if (r < 80) begin
                // broken or unknown commands
                case ($urandom_range(0, 4))
                    0: queue_cmd("RS", 0, rand_sample());
                    1: queue_cmd("O", 0, rand_sample());
                    2: queue_cmd("!RST", 0, rand_sample());
                    3: queue_cmd("ROK", 0, rand_sample());
                    default: queue_cmd("", $urandom_range(0, 4), rand_sample());
                endcase
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    queue_item(ucarl_pkg::KIND_BYTE, 8'($urandom), rand_sample());
                end
            end
        end
    endtask

    task automatic write_timeout(input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ack_timeout = value;
    endtask

    // wait until every request is taken and every byte has come back
    task automatic drain_link();
        do @(negedge aclk);
        while (rx_pending.size() != 0 || s_axis_tvalid || tx_expected.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timeout: echoes, ignored and short commands, report, ack
        queue_item(ucarl_pkg::KIND_BYTE, 8'h00, '0);
        queue_item(ucarl_pkg::KIND_BYTE, 8'hFF, '1);
        queue_item(ucarl_pkg::KIND_TICK, 8'hFF, '1);
        queue_cmd("OK", 0, rand_sample());
        queue_cmd("RS", 0, rand_sample());
        queue_cmd("RST", 0, '0);
        queue_ticks(1);
        queue_cmd("RST", 0, 12'd123);
        queue_cmd("OK", 0, rand_sample());
        drain_link();

        // one-tick timeout: long command with a bang inside, resends
        write_timeout(16'd1);
        queue_cmd("RST!X", 0, '1);
        queue_ticks(2);
        queue_cmd("O", 0, rand_sample());
        queue_cmd("OK", 0, rand_sample());
        drain_link();

        // zero timeout resends on every tick
        write_timeout(16'd0);
        queue_cmd("RST", 0, 12'd9);
        queue_ticks(2);
        queue_cmd("OK", 0, rand_sample());
        drain_link();

        // longest timeout, with the receiver held off while requests queue up
        write_timeout(16'hFFFF);
        queue_random(92);
        @(posedge aclk);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        drain_link();

        // no idling on either side
        calm = 1'b1;
        write_timeout(16'd1);
        queue_random(92);
        drain_link();
        calm = 1'b0;

        write_timeout(16'($urandom_range(2, 12)));
        queue_random(92);
        drain_link();

        write_timeout(16'd4);
        queue_random(92);
        drain_link();

        $display("run covered %0d requests and %0d transmitted bytes", req_count,
                 checked_count);
        $display("reports sent %0d (of them %0d resends), acknowledgements %0d",
                 frame_count, resend_count, ack_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
